// ===== rtl/agc_pkg.sv =====
// Shared types, widths and codes for the accelerometer gesture classifier.
package agc_pkg;

  // Window depth and derived widths
  localparam int DEPTH    = 32;
  localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int SAMP_W   = 16;
  localparam int SQ_W     = 31;
  localparam int SUMSQ_W  = SQ_W + CNT_W;
  localparam int SUMY_W   = SAMP_W + CNT_W;
  localparam int TILTL_W  = 15 + CNT_W;
  localparam int CMP_W    = SUMY_W + 1;

  // Configuration register widths and reset values
  localparam int TAP_W    = 31;
  localparam int SHAKE_W  = 31;
  localparam int TILT_W   = 15;
  localparam logic [TAP_W-1:0]   TAP_RESET   = 31'd24903680;
  localparam logic [SHAKE_W-1:0] SHAKE_RESET = 31'd524288;
  localparam logic [TILT_W-1:0]  TILT_RESET  = 15'd768;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_TAP   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHAKE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TILT  = 2'd2;

  // Gesture codes
  localparam int GEST_W = 3;
  localparam logic [GEST_W-1:0] GEST_NONE  = 3'd0;
  localparam logic [GEST_W-1:0] GEST_TAP   = 3'd1;
  localparam logic [GEST_W-1:0] GEST_SHAKE = 3'd2;
  localparam logic [GEST_W-1:0] GEST_LEFT  = 3'd3;
  localparam logic [GEST_W-1:0] GEST_RIGHT = 3'd4;

  typedef struct packed {
    logic signed [SAMP_W-1:0] z;
    logic signed [SAMP_W-1:0] y;
    logic signed [SAMP_W-1:0] x;
  } sample_t;

  typedef struct packed {
    logic clear;
    logic take;
  } acc_ctl_t;

  typedef struct packed {
    logic [SUMSQ_W-1:0]       sum_x2;
    logic [SUMSQ_W-1:0]       sum_y2;
    logic signed [SUMY_W-1:0] sum_y;
    logic [SQ_W-1:0]          peak_z2;
  } sums_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH,
    ST_DECIDE
  } state_t;

endpackage

// ===== rtl/agc_cell.sv =====
// One window cell: holds a sample and hands it to its neighbor on each shift.
module agc_cell (
  input  logic             clk,
  input  logic             shift,
  input  agc_pkg::sample_t din,
  output agc_pkg::sample_t dout
);

  // Take the neighbor's sample on shift, hold otherwise
  always_ff @(posedge clk) begin
    if (shift) begin
      dout <= din;
    end
  end

endmodule

// ===== rtl/agc_accum.sv =====
// Square and accumulate unit fed by the tail cell of the window chain.
module agc_accum (
  input  logic               clk,
  input  logic               rst,
  input  agc_pkg::acc_ctl_t  ctl,
  input  agc_pkg::sample_t   tail,
  output agc_pkg::sums_t     sums
);

  logic signed [31:0] prod_x;
  logic signed [31:0] prod_y;
  logic signed [31:0] prod_z;

  logic [agc_pkg::SQ_W-1:0]          sq_x;
  logic [agc_pkg::SQ_W-1:0]          sq_y;
  logic [agc_pkg::SQ_W-1:0]          sq_z;
  logic signed [agc_pkg::SAMP_W-1:0] y1;
  logic                              v1;

  // Squares of the tail sample, never negative, at most 2^30
  assign prod_x = $signed(tail.x) * $signed(tail.x);
  assign prod_y = $signed(tail.y) * $signed(tail.y);
  assign prod_z = $signed(tail.z) * $signed(tail.z);

  // Register the squares and the valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ctl.clear) begin
      v1 <= 1'b0;
    end else begin
      v1 <= ctl.take;
    end
  end

  always_ff @(posedge clk) begin
    sq_x <= prod_x[agc_pkg::SQ_W-1:0];
    sq_y <= prod_y[agc_pkg::SQ_W-1:0];
    sq_z <= prod_z[agc_pkg::SQ_W-1:0];
    y1   <= tail.y;
  end

  // Accumulate sums and track peak z squared
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      sums.sum_x2  <= '0;
      sums.sum_y2  <= '0;
      sums.sum_y   <= '0;
      sums.peak_z2 <= '0;
    end else if (v1) begin
      sums.sum_x2 <= sums.sum_x2 + agc_pkg::SUMSQ_W'(sq_x);
      sums.sum_y2 <= sums.sum_y2 + agc_pkg::SUMSQ_W'(sq_y);
      sums.sum_y  <= sums.sum_y + agc_pkg::SUMY_W'(y1);
      if (sq_z > sums.peak_z2) begin
        sums.peak_z2 <= sq_z;
      end
    end
  end

endmodule

// ===== rtl/accel_gesture_classifier.sv =====
// Top level: window cell chain, scan control, threshold decision and output word.
// An accepted input word starts a scan that rotates the cell chain past the single
// square-and-accumulate unit, one cell per cycle, then passes FLUSH and DECIDE, which
// waits for a free output register; a new word is taken only back in IDLE.
// Reset: rst, synchronous, clears state, window count, output valid and loads
// the threshold defaults; the window cells themselves are not reset.
module accel_gesture_classifier (
  input  logic        clk,
  input  logic        rst,
  // Input word: accel_x [15:0], accel_y [31:16], accel_z [47:32]
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,
  // Output word: gesture [2:0], zero fill [7:3]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,
  // Configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  agc_pkg::state_t state;
  agc_pkg::state_t state_next;

  logic [agc_pkg::TAP_W-1:0]   tap_thr;
  logic [agc_pkg::SHAKE_W-1:0] shake_thr;
  logic [agc_pkg::TILT_W-1:0]  tilt_thr;

  logic [agc_pkg::CNT_W-1:0] count;
  logic [agc_pkg::IDX_W-1:0] step;

  logic [agc_pkg::SUMSQ_W-1:0] shake_lim;
  logic [agc_pkg::TILTL_W-1:0] tilt_lim;

  agc_pkg::sample_t  in_sample;
  agc_pkg::sample_t  link [0:agc_pkg::DEPTH];
  agc_pkg::acc_ctl_t acc_ctl;
  agc_pkg::sums_t    sums;

  logic                       load;
  logic                       rotate;
  logic                       last_step;
  logic                       take;
  logic                       out_free;
  logic                       decide_fire;
  logic [agc_pkg::GEST_W-1:0] gesture_c;
  logic [agc_pkg::GEST_W-1:0] gesture;

  logic signed [agc_pkg::CMP_W-1:0] sum_y_c;
  logic signed [agc_pkg::CMP_W-1:0] tilt_c;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == agc_pkg::ST_IDLE);
  assign load          = s_axis_tvalid & s_axis_tready;
  assign rotate        = (state == agc_pkg::ST_SCAN);
  assign last_step     = (step == agc_pkg::IDX_W'(agc_pkg::DEPTH - 1));
  assign out_free      = ~m_axis_tvalid | m_axis_tready;
  assign decide_fire   = (state == agc_pkg::ST_DECIDE) & out_free;

  assign in_sample.x = s_axis_tdata[15:0];
  assign in_sample.y = s_axis_tdata[31:16];
  assign in_sample.z = s_axis_tdata[47:32];

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      tap_thr   <= agc_pkg::TAP_RESET;
      shake_thr <= agc_pkg::SHAKE_RESET;
      tilt_thr  <= agc_pkg::TILT_RESET;
    end else if (cfg_valid & cfg_ready) begin
      unique case (cfg_index)
        agc_pkg::REG_TAP:   tap_thr   <= cfg_data[agc_pkg::TAP_W-1:0];
        agc_pkg::REG_SHAKE: shake_thr <= cfg_data[agc_pkg::SHAKE_W-1:0];
        agc_pkg::REG_TILT:  tilt_thr  <= cfg_data[agc_pkg::TILT_W-1:0];
        default: ;
      endcase
    end
  end

  // Cell chain: new sample enters at the head on load, tail wraps to head on scan
  assign link[0] = load ? in_sample : link[agc_pkg::DEPTH];

  for (genvar i = 0; i < agc_pkg::DEPTH; i++) begin : g_cell
    agc_cell u_cell (
      .clk   (clk),
      .shift (load | rotate),
      .din   (link[i]),
      .dout  (link[i+1])
    );
  end

  // Tail holds original cell DEPTH-1-step; it is live when that index < count
  assign take = rotate &
                ((agc_pkg::CNT_W'(1'b0) + (agc_pkg::CNT_W + 1)'(step)
                  + (agc_pkg::CNT_W + 1)'(count))
                 >= (agc_pkg::CNT_W + 1)'(agc_pkg::DEPTH));

  assign acc_ctl.clear = load;
  assign acc_ctl.take  = take;

  agc_accum u_accum (
    .clk  (clk),
    .rst  (rst),
    .ctl  (acc_ctl),
    .tail (link[agc_pkg::DEPTH]),
    .sums (sums)
  );

  // Scan step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (load) begin
      step <= '0;
    end else if (rotate) begin
      step <= step + agc_pkg::IDX_W'(1);
    end
  end

  // Window fill count: saturate on load, empty on a detection
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (load) begin
      if (count != agc_pkg::CNT_W'(agc_pkg::DEPTH)) begin
        count <= count + agc_pkg::CNT_W'(1);
      end
    end else if (decide_fire && gesture_c != agc_pkg::GEST_NONE) begin
      count <= '0;
    end
  end

  // Scale thresholds by the count while the last square drains
  always_ff @(posedge clk) begin
    if (state == agc_pkg::ST_FLUSH) begin
      shake_lim <= agc_pkg::SUMSQ_W'(shake_thr) * agc_pkg::SUMSQ_W'(count);
      tilt_lim  <= agc_pkg::TILTL_W'(tilt_thr) * agc_pkg::TILTL_W'(count);
    end
  end

  // Classify: tap, shake, left tilt, right tilt in priority order
  assign sum_y_c = agc_pkg::CMP_W'(sums.sum_y);
  assign tilt_c  = $signed(agc_pkg::CMP_W'(tilt_lim));

  always_comb begin
    if (sums.peak_z2 > tap_thr) begin
      gesture_c = agc_pkg::GEST_TAP;
    end else if (sums.sum_x2 > shake_lim && sums.sum_y2 > shake_lim) begin
      gesture_c = agc_pkg::GEST_SHAKE;
    end else if (sum_y_c < -tilt_c) begin
      gesture_c = agc_pkg::GEST_LEFT;
    end else if (sum_y_c > tilt_c) begin
      gesture_c = agc_pkg::GEST_RIGHT;
    end else begin
      gesture_c = agc_pkg::GEST_NONE;
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= agc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      agc_pkg::ST_IDLE: begin
        if (load) state_next = agc_pkg::ST_SCAN;
      end
      agc_pkg::ST_SCAN: begin
        if (last_step) state_next = agc_pkg::ST_FLUSH;
      end
      agc_pkg::ST_FLUSH: begin
        state_next = agc_pkg::ST_DECIDE;
      end
      agc_pkg::ST_DECIDE: begin
        if (out_free) state_next = agc_pkg::ST_IDLE;
      end
      default: state_next = agc_pkg::ST_IDLE;
    endcase
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (decide_fire) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (decide_fire) begin
      gesture <= gesture_c;
    end
  end

  assign m_axis_tdata = {5'b0, gesture};

  // Fill count never passes the window depth
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= agc_pkg::CNT_W'(agc_pkg::DEPTH))
    else $error("window count beyond depth");

  // A detection empties the window
  a_clear_on_detect: assert property (@(posedge clk) disable iff (rst)
    (decide_fire && gesture_c != agc_pkg::GEST_NONE) |=> count == '0)
    else $error("window not emptied after detection");

  // An accepted word starts the scan with the step counter at zero
  a_scan_start: assert property (@(posedge clk) disable iff (rst)
    load |=> (state == agc_pkg::ST_SCAN && step == '0))
    else $error("scan did not start after load");

  // A presented result is a defined gesture code
  a_gesture_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (gesture <= agc_pkg::GEST_RIGHT))
    else $error("gesture code out of range");

endmodule
